### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/fdec_pkg.sv
// types, constants and coefficient table of the 48 kHz to 8 kHz decimator
package fdec_pkg;

    localparam int COEF_W    = 18;
    localparam int COEF_FRAC = 17;
    localparam int HALF_TAPS = 60;

    // first half of the symmetric low-pass response, Q1.17
    localparam logic signed [COEF_W-1:0] HALF_COEFS [HALF_TAPS] = '{
        -18'sd1,     18'sd0,      18'sd1,      18'sd3,      18'sd6,
        18'sd7,      18'sd7,      18'sd4,      -18'sd3,     -18'sd13,
        -18'sd24,    -18'sd32,    -18'sd33,    -18'sd24,    -18'sd3,
        18'sd28,     18'sd63,     18'sd91,     18'sd102,    18'sd86,
        18'sd40,     -18'sd33,    -18'sd120,   -18'sd199,   -18'sd245,
        -18'sd235,   -18'sd155,   -18'sd12,    18'sd173,    18'sd358,
        18'sd492,    18'sd524,    18'sd422,    18'sd182,    -18'sd163,
        -18'sd542,   -18'sd861,   -18'sd1022,  -18'sd946,   -18'sd603,
        -18'sd27,    18'sd681,    18'sd1362,   18'sd1832,   18'sd1922,
        18'sd1525,   18'sd634,    -18'sd634,   -18'sd2043,  -18'sd3265,
        -18'sd3940,  -18'sd3744,  -18'sd2461,  -18'sd40,    18'sd3371,
        18'sd7434,   18'sd11666,  18'sd15509,  18'sd18429,  18'sd20004
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_DONE
    } fdec_state_t;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

endpackage

### hdl/fdec_if.sv
// stream interfaces for the input and output samples
interface fdec_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface fdec_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

### hdl/fdec_mac.sv
// multiply-accumulate unit with round-half-up and saturation to the sample width
module fdec_mac #(
    parameter int SAMPLE_BITS = 16,
    parameter int TAP_COUNT   = 120
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fdec_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic signed [fdec_pkg::COEF_W-1:0]    coef,
    output logic                                  busy,
    output logic signed [SAMPLE_BITS-1:0]         result
);

    localparam int PROD_W = SAMPLE_BITS + fdec_pkg::COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT);
    localparam int QW     = ACC_W - fdec_pkg::COEF_FRAC;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        ACC_W'(64'd1 << (fdec_pkg::COEF_FRAC - 1));
    localparam logic signed [QW-1:0] Q_MAX = QW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [QW-1:0] Q_MIN = -Q_MAX - QW'(1);

    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  biased;
    logic signed [QW-1:0]     q;

    assign prod_next = PROD_W'(sample) * PROD_W'(coef);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // round half up, floor shift, then clamp
    assign biased = acc_reg + ROUND_BIAS;
    assign q      = QW'(biased >>> fdec_pkg::COEF_FRAC);

    always_comb
    begin
        if (q > Q_MAX)
        begin
            result = Q_MAX[SAMPLE_BITS-1:0];
        end
        else if (q < Q_MIN)
        begin
            result = Q_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            result = q[SAMPLE_BITS-1:0];
        end
    end

    assign busy = prod_valid_reg;

endmodule

### hdl/fir_decimator_by_six.sv
// top level of the 120-tap fir decimator, 48 kHz in, 8 kHz out
//
//  channel      | dir | payload              | transaction
//  -------------+-----+----------------------+-------------------------------
//  in_stream    | in  | sample_in  (s, Q1.15) | one 48 kHz sample
//  out_stream   | out | sample_out (s, Q1.15) | one 8 kHz sample, every sixth
//
//  an input that does not complete a group of DECIMATION is taken without leaving
//  the idle state, so such inputs can stream back to back
//  the input that completes a group starts one pass over the delay line memory:
//  a read of every tap on the single read port, a drain of the multiply-accumulate
//  pipeline, then a load of the output register, with ready low throughout; the
//  load waits while the output register still holds an unaccepted result
//  reset clears all control at once; the delay line memory is not swept, a fill
//  count marks which taps hold samples, the rest read as zero
//  a result waiting in the output register does not stop input; only the next
//  finished result waits for it
module fir_decimator_by_six #(
    parameter int TAP_COUNT   = 120,
    parameter int DECIMATION  = 6,
    parameter int SAMPLE_BITS = 16
) (
    input logic        clk,
    input logic        rst_n,
    fdec_in_if.sink    in_stream,
    fdec_out_if.source out_stream
);

    localparam int AW    = $clog2(TAP_COUNT);
    localparam int FW    = $clog2(TAP_COUNT + 1);
    localparam int PHW   = $clog2(DECIMATION);
    localparam int IDX_W = (AW > 6) ? AW : 6;

    localparam logic [AW-1:0]  LAST_TAP   = AW'(TAP_COUNT - 1);
    localparam logic [FW-1:0]  FULL_COUNT = FW'(TAP_COUNT);
    localparam logic [PHW-1:0] LAST_PHASE = PHW'(DECIMATION - 1);

    // delay line memory, one write port, one registered read port
    logic [SAMPLE_BITS-1:0] mem [TAP_COUNT];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    fdec_pkg::fdec_state_t state_reg;
    fdec_pkg::fdec_state_t state_next;

    // write side
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [FW-1:0]  fill_reg;
    logic [FW-1:0]  fill_next;
    logic [PHW-1:0] phase_reg;
    logic [PHW-1:0] phase_next;

    // read sweep
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [AW-1:0]  k_reg;
    logic [AW-1:0]  k_next;

    // stage aligned with the memory read data
    logic                                s1_valid_reg;
    logic                                s1_live_reg;
    logic signed [fdec_pkg::COEF_W-1:0]  s1_coef_reg;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;

    // sequencer outputs
    logic in_ready;
    logic issue;
    logic load_out;

    logic in_acc;
    logic trigger;
    logic tap_live;

    // coefficient for tap k from the symmetric half table
    logic [AW-1:0]                      mirror;
    logic [IDX_W-1:0]                   m_ext;
    logic signed [fdec_pkg::COEF_W-1:0] coef_k;

    fdec_pkg::mac_ctrl_t           mac_ctrl;
    logic signed [SAMPLE_BITS-1:0] mac_sample;
    logic                          mac_busy;
    logic signed [SAMPLE_BITS-1:0] mac_result;

    assign in_acc  = in_stream.valid && in_ready;
    assign trigger = (phase_reg == LAST_PHASE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fdec_pkg::ST_IDLE:
            begin
                if (in_acc && trigger)
                begin
                    state_next = fdec_pkg::ST_MAC;
                end
            end
            fdec_pkg::ST_MAC:
            begin
                if (k_reg == LAST_TAP)
                begin
                    state_next = fdec_pkg::ST_DRAIN;
                end
            end
            fdec_pkg::ST_DRAIN:
            begin
                // wait until the last product has reached the accumulator
                if (!s1_valid_reg && !mac_busy)
                begin
                    state_next = fdec_pkg::ST_DONE;
                end
            end
            fdec_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_stream.ready)
                begin
                    state_next = fdec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fdec_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            fdec_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            fdec_pkg::ST_MAC:
            begin
                issue = 1'b1;
            end
            fdec_pkg::ST_DRAIN:
            begin
                in_ready = 1'b0;
            end
            fdec_pkg::ST_DONE:
            begin
                load_out = !out_valid_reg || out_stream.ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // write pointer and phase advance on each accepted sample, the fill count until it reaches TAP_COUNT
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        phase_next  = phase_reg;
        if (in_acc)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_TAP) ? '0 : wr_ptr_reg + 1'b1;
            if (fill_reg != FULL_COUNT)
            begin
                fill_next = fill_reg + 1'b1;
            end
            phase_next = trigger ? '0 : phase_reg + 1'b1;
        end
    end

    // read sweep walks from the newest sample back to the oldest
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        k_next      = k_reg;
        if (in_acc)
        begin
            rd_ptr_next = wr_ptr_reg;
            k_next      = '0;
        end
        else if (issue)
        begin
            rd_ptr_next = (rd_ptr_reg == '0) ? LAST_TAP : rd_ptr_reg - 1'b1;
            k_next      = k_reg + 1'b1;
        end
    end

    assign mirror = LAST_TAP - k_reg;
    assign m_ext  = (k_reg < mirror) ? IDX_W'(k_reg) : IDX_W'(mirror);

    always_comb
    begin
        if (m_ext < IDX_W'(fdec_pkg::HALF_TAPS))
        begin
            coef_k = fdec_pkg::HALF_COEFS[m_ext[5:0]];
        end
        else
        begin
            coef_k = '0;
        end
    end

    // taps not yet written since reset weigh as zero samples
    assign tap_live = (FW'(k_reg) < fill_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fdec_pkg::ST_IDLE;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            phase_reg     <= '0;
            rd_ptr_reg    <= '0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s1_live_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            rd_ptr_reg    <= rd_ptr_next;
            k_reg         <= k_next;
            s1_valid_reg  <= issue;
            s1_live_reg   <= issue && tap_live;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_coef_reg <= coef_k;
        if (load_out)
        begin
            out_data_reg <= mac_result;
        end
    end

    // the sweep starts the cycle after the write and no write happens during
    // it, so read and write never meet on one entry
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mem[wr_ptr_reg] <= in_stream.sample_in;
        end
        rd_data_reg <= mem[rd_ptr_reg];
    end

    assign mac_sample     = s1_live_reg ? $signed(rd_data_reg) : '0;
    assign mac_ctrl.clear = in_acc && trigger;
    assign mac_ctrl.valid = s1_valid_reg;

    fdec_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TAP_COUNT   (TAP_COUNT)
    ) u_fdec_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .sample (mac_sample),
        .coef   (s1_coef_reg),
        .busy   (mac_busy),
        .result (mac_result)
    );

    assign in_stream.ready       = in_ready;
    assign out_stream.valid      = out_valid_reg;
    assign out_stream.sample_out = out_data_reg;

endmodule

### hdl/fdec_checker.sv
// port-level checks for the decimator and their binding to the top level
`include "assert_macros.svh"

module fdec_checker #(
    parameter int DECIMATION  = 6,
    parameter int SAMPLE_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] out_data
);

    localparam int PHW = $clog2(DECIMATION);
    localparam logic [PHW-1:0] LAST_PHASE = PHW'(DECIMATION - 1);

    logic [PHW-1:0] phase_reg;
    logic [PHW-1:0] phase_next;
    logic [2:0]     owed_reg;
    logic [2:0]     owed_next;
    logic           in_acc;
    logic           out_acc;
    logic           trigger;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign trigger = in_acc && (phase_reg == LAST_PHASE);

    always_comb
    begin
        phase_next = phase_reg;
        if (in_acc)
        begin
            phase_next = (phase_reg == LAST_PHASE) ? '0 : phase_reg + 1'b1;
        end
        owed_next = owed_reg + 3'(trigger) - 3'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            owed_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            owed_reg  <= owed_next;
        end
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output valid dropped while stalled")
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data), "output data changed while stalled")
    `ASSERT_IMPL(a_no_extra, clk, rst_n, out_valid, owed_reg != 3'd0, "output without a completed group")
    `ASSERT_IMPL(a_owed_bound, clk, rst_n, 1'b1, owed_reg <= 3'd2, "more than two results outstanding")
    `ASSERT_NEXT(a_busy_after_group, clk, rst_n, trigger, !in_ready, "input taken during a filter pass")

endmodule

bind fir_decimator_by_six fdec_checker #(
    .DECIMATION  (DECIMATION),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fdec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .out_data  (out_stream.sample_out)
);
